[hw/rtl/wavetable_psg_mixer_top_defines.svh]
// Assertion macros of the wavetable sound generator RTL, used by the back end.
`ifndef WAVETABLE_PSG_MIXER_TOP_DEFINES_SVH
`define WAVETABLE_PSG_MIXER_TOP_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset.
`define WPM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define WPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/wpm_pkg.sv]
// Shared types, constants and lookup functions of the wavetable sound generator.
`default_nettype none
package wpm_pkg;

    localparam int VOICE_COUNT   = 6;
    localparam int REGISTER_SETS = 8;
    localparam int WAVE_LENGTH   = 32;

    localparam int SET_W     = $clog2(REGISTER_SETS);
    localparam int WAVE_W    = $clog2(WAVE_LENGTH);
    localparam int RAM_DEPTH = REGISTER_SETS * WAVE_LENGTH;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int VCNT_W    = SET_W + 1;
    localparam int NOISE_FIRST = 4;

    localparam int RATIO_W = 24;
    localparam int DVD_W   = RATIO_W + 4;
    localparam int DVS_W   = 13;
    localparam int PHASE_W = 17;
    localparam int NACC_W  = 11;
    localparam int LEVEL_W = 5;
    localparam int VOL_W   = 9;
    localparam int SAMPLE_W = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [RATIO_W-1:0] RATIO_RESET = 24'd20779;
    localparam logic [15:0]        LFSR_TAPS   = 16'hB400;
    localparam logic [15:0]        LFSR_RESET  = 16'h0001;
    localparam logic [DVS_W-1:0]   PERIOD_ZERO_DIV = 13'd4096;

    localparam logic [3:0] ADDR_SELECT    = 4'd0;
    localparam logic [3:0] ADDR_GBAL      = 4'd1;
    localparam logic [3:0] ADDR_PERIOD_LO = 4'd2;
    localparam logic [3:0] ADDR_PERIOD_HI = 4'd3;
    localparam logic [3:0] ADDR_CONTROL   = 4'd4;
    localparam logic [3:0] ADDR_CHBAL     = 4'd5;
    localparam logic [3:0] ADDR_DATA      = 4'd6;
    localparam logic [3:0] ADDR_NOISE     = 4'd7;

    localparam logic [1:0] MODE_DIRECT = 2'b11;
    localparam logic [1:0] MODE_HOLD   = 2'b01;

    typedef enum logic {OP_WRITE, OP_TICK} op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [3:0] addr;
        logic [7:0] value;
    } op_t;

    typedef enum logic [1:0] {ST_IDLE, ST_CHAN, ST_DIV, ST_MIX} core_state_t;
    typedef enum logic [1:0] {SRC_WAVE, SRC_DIRECT, SRC_NOISE} src_t;

    function automatic logic [LEVEL_W-1:0] bal_map(input logic [3:0] nib);
        logic [LEVEL_W-1:0] r;
        case (nib)
            4'd0:    r = 5'd0;
            4'd1:    r = 5'd3;
            4'd2:    r = 5'd5;
            4'd3:    r = 5'd7;
            4'd4:    r = 5'd9;
            4'd5:    r = 5'd11;
            4'd6:    r = 5'd13;
            4'd7:    r = 5'd15;
            4'd8:    r = 5'd16;
            4'd9:    r = 5'd19;
            4'd10:   r = 5'd21;
            4'd11:   r = 5'd23;
            4'd12:   r = 5'd25;
            4'd13:   r = 5'd27;
            4'd14:   r = 5'd29;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic [VOL_W-1:0] vol_rom(input logic [4:0] k);
        logic [VOL_W-1:0] r;
        case (k)
            5'd0:  r = 9'd341;  5'd1:  r = 9'd287;  5'd2:  r = 9'd241;  5'd3:  r = 9'd203;
            5'd4:  r = 9'd171;  5'd5:  r = 9'd143;  5'd6:  r = 9'd121;  5'd7:  r = 9'd101;
            5'd8:  r = 9'd85;   5'd9:  r = 9'd72;   5'd10: r = 9'd60;   5'd11: r = 9'd51;
            5'd12: r = 9'd42;   5'd13: r = 9'd36;   5'd14: r = 9'd30;   5'd15: r = 9'd25;
            5'd16: r = 9'd21;   5'd17: r = 9'd18;   5'd18: r = 9'd15;   5'd19: r = 9'd12;
            5'd20: r = 9'd10;   5'd21: r = 9'd9;    5'd22: r = 9'd7;    5'd23: r = 9'd6;
            5'd24: r = 9'd5;    5'd25: r = 9'd4;    5'd26: r = 9'd3;    5'd27: r = 9'd3;
            5'd28: r = 9'd2;    5'd29: r = 9'd2;    5'd30: r = 9'd1;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Total attenuation of channel balance, level and global balance, capped.
    function automatic logic [VOL_W-1:0] atten_vol(input logic [3:0] chb,
                                                  input logic [3:0] glb,
                                                  input logic [LEVEL_W-1:0] lvl);
        logic [6:0] a;
        a = 7'(5'd31 - bal_map(chb)) + 7'(5'd31 - lvl) + 7'(5'd31 - bal_map(glb));
        if (a > 7'd31) begin
            a = 7'd31;
        end
        return vol_rom(a[4:0]);
    endfunction

endpackage
`default_nettype wire

[hw/rtl/wpm_front.sv]
// Front end: accepts items, classifies them and queues them for the back end.
`default_nettype none
module wpm_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_action,
    input  wire logic [3:0]    s_address,
    input  wire logic [7:0]    s_value,
    output logic               q_valid,
    output wpm_pkg::op_t       q_op,
    input  wire logic          q_pop
);
    import wpm_pkg::*;

    op_t               fifo_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;
    op_t               in_op;

    assign s_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_op    = fifo_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        in_op.kind  = s_action ? OP_TICK : OP_WRITE;
        in_op.addr  = s_address;
        in_op.value = s_value;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/wpm_div.sv]
// Restoring divider producing one quotient bit per cycle for the step sizes.
`default_nettype none
module wpm_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [wpm_pkg::DVD_W-1:0]   dividend,
    input  wire logic [wpm_pkg::DVS_W-1:0]   divisor,
    output logic                             busy,
    output logic                             done,
    output logic [wpm_pkg::DVD_W-1:0]        quotient
);
    import wpm_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dq_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dq_reg;

    always_comb begin
        rem_sh = {rem_reg, dq_reg[DVD_W-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        ge     = (rem_sh >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            dq_reg  <= {dq_reg[DVD_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/wpm_core.sv]
// Back end: register file, wave memory, channel sequencer and stereo mixer.
`default_nettype none
`include "wavetable_psg_mixer_top_defines.svh"
module wpm_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [wpm_pkg::RATIO_W-1:0]   ratio,
    input  wire logic                          q_valid,
    input  wire wpm_pkg::op_t                  q_op,
    output logic                               q_pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [wpm_pkg::SAMPLE_W-1:0] m_left_sample,
    output logic signed [wpm_pkg::SAMPLE_W-1:0] m_right_sample
);
    import wpm_pkg::*;

    core_state_t state_reg, state_next;

    logic [SET_W-1:0]   sel_reg;
    logic [7:0]         gbal_reg;
    logic [11:0]        tone_reg   [REGISTER_SETS];
    logic [7:0]         ctl_reg    [REGISTER_SETS];
    logic [7:0]         chbal_reg  [REGISTER_SETS];
    logic [WAVE_W-1:0]  wwi_reg    [REGISTER_SETS];
    logic [LEVEL_W-1:0] direct_reg [REGISTER_SETS];
    logic [7:0]         noise_reg  [REGISTER_SETS];
    logic [PHASE_W-1:0] phase_reg  [REGISTER_SETS];
    logic [NACC_W-1:0]  nacc_reg   [REGISTER_SETS];
    logic [LEVEL_W-1:0] nlvl_reg   [REGISTER_SETS];
    logic [15:0]        lfsr_reg;

    logic [VCNT_W-1:0]  ch_reg;
    logic [VOL_W-1:0]   vl_reg, vr_reg;
    src_t               src_reg;
    logic [LEVEL_W-1:0] smp_reg;
    logic [SAMPLE_W-1:0] left_reg, right_reg;
    logic               m_valid_reg;

    logic [LEVEL_W-1:0] wave_mem [RAM_DEPTH];
    logic [RAM_DEPTH-1:0] wave_vld_reg;
    logic [LEVEL_W-1:0] rd_data_reg;
    logic               rd_vld_reg;

    logic do_write, tick_start, chan_skip, chan_go, div_start, div_finish, mix, out_load;
    logic [SET_W-1:0]   idx;
    logic [SET_W-1:0]   ch_idx;
    logic [7:0]         ctl;
    src_t               src_cur;
    logic               wave_wr;
    logic [RAM_AW-1:0]  wr_addr, rd_addr;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic [5:0]         noise_n;
    logic               div_busy, div_done;
    logic [DVD_W-1:0]   div_q;
    logic [NACC_W:0]    nsum;
    logic               nfire;
    logic               lfsr_out;
    logic [15:0]        lfsr_next;
    logic [LEVEL_W-1:0] nlvl_new;
    logic signed [5:0]  smp_off;
    logic signed [SAMPLE_W-1:0] lprod, rprod;

    assign ch_idx = ch_reg[SET_W-1:0];
    assign idx    = (state_reg == ST_IDLE) ? sel_reg : ch_idx;
    assign ctl    = ctl_reg[idx];

    always_comb begin
        if ((ch_reg >= VCNT_W'(NOISE_FIRST)) && noise_reg[idx][7]) begin
            src_cur = SRC_NOISE;
        end else if (ctl[6]) begin
            src_cur = SRC_DIRECT;
        end else begin
            src_cur = SRC_WAVE;
        end
    end

    always_comb begin
        noise_n = 6'({1'b0, noise_reg[idx][4:0] ^ 5'h1F}) + 6'd1;
        if (src_cur == SRC_NOISE) begin
            div_dvd = DVD_W'(ratio);
            div_dvs = DVS_W'({noise_n, 3'b000});
        end else begin
            div_dvd = {ratio, 4'b0000};
            div_dvs = (tone_reg[idx] == '0) ? PERIOD_ZERO_DIV : {1'b0, tone_reg[idx]};
        end
    end

    assign wave_wr = do_write && (q_op.addr == ADDR_DATA) && (ctl[7:6] != MODE_DIRECT)
                     && (ctl[7:6] != MODE_HOLD);
    assign wr_addr = {sel_reg, wwi_reg[sel_reg]};
    assign rd_addr = {ch_idx, phase_reg[ch_idx][PHASE_W-1 -: WAVE_W]};

    always_comb begin
        nsum      = {1'b0, nacc_reg[ch_idx]} + {1'b0, div_q[NACC_W-1:0]};
        nfire     = (|div_q[DVD_W-1:NACC_W]) || nsum[NACC_W];
        lfsr_out  = lfsr_reg[0];
        lfsr_next = (lfsr_reg >> 1) ^ (lfsr_out ? LFSR_TAPS : 16'h0000);
        nlvl_new  = lfsr_out ? 5'h1F : 5'h00;
        smp_off   = $signed({1'b0, smp_reg}) - 6'sd16;
        lprod     = $signed({1'b0, vl_reg}) * smp_off;
        rprod     = $signed({1'b0, vr_reg}) * smp_off;
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        do_write   = 1'b0;
        tick_start = 1'b0;
        chan_skip  = 1'b0;
        chan_go    = 1'b0;
        div_start  = 1'b0;
        div_finish = 1'b0;
        mix        = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_op.kind == OP_WRITE) begin
                        q_pop    = 1'b1;
                        do_write = 1'b1;
                    end else if (!m_valid_reg) begin
                        q_pop      = 1'b1;
                        tick_start = 1'b1;
                        state_next = ST_CHAN;
                    end
                end
            end
            ST_CHAN: begin
                if (ch_reg == VCNT_W'(VOICE_COUNT)) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end else if (!ctl[7]) begin
                    chan_skip = 1'b1;
                end else begin
                    chan_go = 1'b1;
                    if (src_cur == SRC_DIRECT) begin
                        state_next = ST_MIX;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    div_finish = 1'b1;
                    state_next = ST_MIX;
                end
            end
            ST_MIX: begin
                mix        = 1'b1;
                state_next = ST_CHAN;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    wpm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Wave memory with registered read.
    always_ff @(posedge aclk) begin
        if (wave_wr) begin
            wave_mem[wr_addr] <= q_op.value[LEVEL_W-1:0];
        end
        rd_data_reg <= wave_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end else begin
            if (wave_wr) begin
                wave_vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= wave_vld_reg[rd_addr];
        end
    end

    // Datapath registers that carry one channel through the mixer.
    always_ff @(posedge aclk) begin
        if (chan_go) begin
            vl_reg  <= atten_vol(chbal_reg[idx][7:4], gbal_reg[7:4], ctl[4:0]);
            vr_reg  <= atten_vol(chbal_reg[idx][3:0], gbal_reg[3:0], ctl[4:0]);
            src_reg <= src_cur;
            if (src_cur == SRC_DIRECT) begin
                smp_reg <= direct_reg[idx];
            end
        end else if (div_finish) begin
            if (src_reg == SRC_NOISE) begin
                smp_reg <= nfire ? nlvl_new : nlvl_reg[ch_idx];
            end else begin
                smp_reg <= rd_vld_reg ? rd_data_reg : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sel_reg     <= '0;
            gbal_reg    <= '0;
            lfsr_reg    <= LFSR_RESET;
            ch_reg      <= '0;
            left_reg    <= '0;
            right_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < REGISTER_SETS; i++) begin
                tone_reg[i]   <= '0;
                ctl_reg[i]    <= '0;
                chbal_reg[i]  <= '0;
                wwi_reg[i]    <= '0;
                direct_reg[i] <= '0;
                noise_reg[i]  <= '0;
                phase_reg[i]  <= '0;
                nacc_reg[i]   <= '0;
                nlvl_reg[i]   <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (do_write) begin
                case (q_op.addr)
                    ADDR_SELECT:    sel_reg <= q_op.value[SET_W-1:0];
                    ADDR_GBAL:      gbal_reg <= q_op.value;
                    ADDR_PERIOD_LO: tone_reg[sel_reg][7:0] <= q_op.value;
                    ADDR_PERIOD_HI: tone_reg[sel_reg][11:8] <= q_op.value[3:0];
                    ADDR_CONTROL: begin
                        if (ctl[6] && !q_op.value[6]) begin
                            wwi_reg[sel_reg] <= '0;
                        end
                        ctl_reg[sel_reg] <= q_op.value;
                    end
                    ADDR_CHBAL:     chbal_reg[sel_reg] <= q_op.value;
                    ADDR_DATA: begin
                        if (ctl[7:6] == MODE_DIRECT) begin
                            direct_reg[sel_reg] <= q_op.value[LEVEL_W-1:0];
                        end else if (ctl[7:6] != MODE_HOLD) begin
                            wwi_reg[sel_reg] <= wwi_reg[sel_reg] + 1'b1;
                        end
                    end
                    ADDR_NOISE:     noise_reg[sel_reg] <= q_op.value;
                    default: ;
                endcase
            end

            if (tick_start) begin
                ch_reg    <= '0;
                left_reg  <= '0;
                right_reg <= '0;
            end else if (chan_skip || mix) begin
                ch_reg <= ch_reg + 1'b1;
            end

            if (mix) begin
                left_reg  <= left_reg + lprod;
                right_reg <= right_reg + rprod;
            end

            if (div_finish) begin
                if (src_reg == SRC_NOISE) begin
                    nacc_reg[ch_idx] <= nsum[NACC_W-1:0];
                    if (nfire) begin
                        lfsr_reg         <= lfsr_next;
                        nlvl_reg[ch_idx] <= nlvl_new;
                    end
                end else begin
                    phase_reg[ch_idx] <= phase_reg[ch_idx] + div_q[PHASE_W-1:0];
                end
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_left_sample  = left_reg;
    assign m_right_sample = right_reg;

    `WPM_ASSERT_IMPL(a_out_free, out_load, !m_valid_reg, "sample loaded over a pending one")
    `WPM_ASSERT_IMPL(a_div_idle, div_start, !div_busy, "divider restarted while busy")
    `WPM_ASSERT_IMPL(a_div_src, state_reg == ST_DIV, src_reg != SRC_DIRECT,
                     "divider wait for a direct-level channel")
    `WPM_ASSERT_NEXT(a_tick_clear, tick_start, (ch_reg == '0) && (left_reg == '0),
                     "tick did not restart the mix")

endmodule
`default_nettype wire

[hw/rtl/wavetable_psg_mixer_top.sv]
// Top level of the six-channel wavetable sound generator with stereo mixer.
// A register write waits in the front queue and is applied when the idle back end takes it.
// A sample is built by walking the channels: disabled and direct-level channels skip the
// bit-serial step divider, while each wave or noise channel waits for it.
// Up to four items queue in front, so the input accepts while a sample waits, until the queue fills.
// aresetn is synchronous and active low; it clears the control state and marks the wave store empty.
`default_nettype none
module wavetable_psg_mixer_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [wpm_pkg::RATIO_W-1:0]    cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_action,
    input  wire logic [3:0]                     s_address,
    input  wire logic [7:0]                     s_value,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [wpm_pkg::SAMPLE_W-1:0] m_left_sample,
    output logic signed [wpm_pkg::SAMPLE_W-1:0] m_right_sample
);
    import wpm_pkg::*;

    // Clock rate ratio, to be written only while the generator is idle; the block does not enforce it.
    logic [RATIO_W-1:0] ratio_reg;
    logic               q_valid;
    logic               q_pop;
    op_t                q_op;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg <= RATIO_RESET;
        end else if (cfg_we) begin
            ratio_reg <= cfg_wdata;
        end
    end

    // The front end classifies each transfer and queues it.
    wpm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_address (s_address),
        .s_value   (s_value),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_pop     (q_pop)
    );

    // The back end applies writes and walks the channels for each tick.
    wpm_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ratio          (ratio_reg),
        .q_valid        (q_valid),
        .q_op           (q_op),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_sample  (m_left_sample),
        .m_right_sample (m_right_sample)
    );

endmodule
`default_nettype wire

[bench/tb_wavetable_psg_mixer_top.sv]
// Self-checking bench of the six-channel wavetable sound generator and mixer.
`default_nettype none
module tb_wavetable_psg_mixer_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wpm_pkg::*;

    // Clock, reset and the ports of the block.
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [RATIO_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_action = 1'b0;
    logic [3:0] s_address = '0;
    logic [7:0] s_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_left_sample;
    logic signed [SAMPLE_W-1:0] m_right_sample;

    wavetable_psg_mixer_top dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_address(s_address), .s_value(s_value), .m_valid(m_valid),
        .m_ready(m_ready), .m_left_sample(m_left_sample),
        .m_right_sample(m_right_sample)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // One expected stereo sample, waiting for the block to deliver it.
    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
    } stereo_t;
    stereo_t sample_queue[$];

    int errors = 0;
    int cycle_count = 0;
    int ticks_sent = 0;
    int writes_sent = 0;
    int samples_seen = 0;
    int configs_done = 0;
    localparam int CYCLE_LIMIT = 2000000;

    // Receiver and sender controls: random idling, a long hold-off, and a quiet tail.
    bit rx_idle_on = 1'b1;
    bit rx_hold_req = 1'b0;
    bit tx_idle_on = 1'b1;

    // The bench's own copy of the generator state.
    logic [RATIO_W-1:0] m_ratio;
    logic [2:0]  m_sel;
    logic [7:0]  m_gbal;
    logic [11:0] m_period[REGISTER_SETS];
    logic [7:0]  m_ctl[REGISTER_SETS];
    logic [7:0]  m_chbal[REGISTER_SETS];
    logic [4:0]  m_wave[REGISTER_SETS][WAVE_LENGTH];
    logic [4:0]  m_widx[REGISTER_SETS];
    logic [4:0]  m_direct[REGISTER_SETS];
    logic [7:0]  m_noise[REGISTER_SETS];
    logic [16:0] m_phase[REGISTER_SETS];
    logic [10:0] m_nacc[REGISTER_SETS];
    logic [4:0]  m_nlvl[REGISTER_SETS];
    logic [15:0] m_lfsr;

    function automatic int nibble_level(input logic [3:0] nib);
        int lut[16] = '{0, 3, 5, 7, 9, 11, 13, 15, 16, 19, 21, 23, 25, 27, 29, 31};
        return lut[nib];
    endfunction

    function automatic int channel_gain(input logic [3:0] chb, input logic [3:0] glb,
                                        input logic [4:0] lvl);
        int rom[32] = '{341, 287, 241, 203, 171, 143, 121, 101, 85, 72, 60, 51, 42,
                        36, 30, 25, 21, 18, 15, 12, 10, 9, 7, 6, 5, 4, 3, 3, 2, 2, 1, 0};
        int a;
        a = (31 - nibble_level(chb)) + (31 - int'(lvl)) + (31 - nibble_level(glb));
        if (a > 31) begin
            a = 31;
        end
        return rom[a];
    endfunction

    task automatic reset_generator_model();
        m_ratio = RATIO_RESET;
        m_sel = '0;
        m_gbal = '0;
        for (int c = 0; c < REGISTER_SETS; c++) begin
            m_period[c] = '0; m_ctl[c] = '0; m_chbal[c] = '0; m_widx[c] = '0;
            m_direct[c] = '0; m_noise[c] = '0; m_phase[c] = '0; m_nacc[c] = '0;
            m_nlvl[c] = '0;
            for (int i = 0; i < WAVE_LENGTH; i++) begin
                m_wave[c][i] = '0;
            end
        end
        m_lfsr = LFSR_RESET;
    endtask

    // Apply one accepted item to the copy; a tick yields the expected mix.
    task automatic predict_mix(input logic act, input logic [3:0] addr,
                               input logic [7:0] v);
        int left, right, vl, vr, smp;
        logic [2:0] c;
        logic [31:0] inc, acc, d;
        logic [4:0] pos;
        logic bit_out;
        stereo_t s;
        left = 0;
        right = 0;
        c = m_sel;
        if (act == OP_WRITE) begin
            case (addr)
                ADDR_SELECT:    m_sel = v[2:0];
                ADDR_GBAL:      m_gbal = v;
                ADDR_PERIOD_LO: m_period[c][7:0] = v;
                ADDR_PERIOD_HI: m_period[c][11:8] = v[3:0];
                ADDR_CONTROL: begin
                    // Dropping the direct bit rewinds the wave write pointer.
                    if (m_ctl[c][6] && !v[6]) begin
                        m_widx[c] = '0;
                    end
                    m_ctl[c] = v;
                end
                ADDR_CHBAL:     m_chbal[c] = v;
                ADDR_DATA: begin
                    if (m_ctl[c][7:6] == MODE_DIRECT) begin
                        m_direct[c] = v[4:0];
                    end else if (m_ctl[c][7:6] != MODE_HOLD) begin
                        m_wave[c][m_widx[c]] = v[4:0];
                        m_widx[c] = m_widx[c] + 5'd1;
                    end
                end
                ADDR_NOISE:     m_noise[c] = v;
                default: ;
            endcase
            return;
        end
        for (int ch = 0; ch < VOICE_COUNT; ch++) begin
            if (m_ctl[ch][7]) begin
                vl = channel_gain(m_chbal[ch][7:4], m_gbal[7:4], m_ctl[ch][4:0]);
                vr = channel_gain(m_chbal[ch][3:0], m_gbal[3:0], m_ctl[ch][4:0]);
                if (ch >= NOISE_FIRST && m_noise[ch][7]) begin
                    inc = 32'(m_ratio) / (32'd8 * (32'(m_noise[ch][4:0] ^ 5'h1F) + 32'd1));
                    acc = 32'(m_nacc[ch]) + inc;
                    if (acc >= 32'h800) begin
                        bit_out = m_lfsr[0];
                        m_lfsr = m_lfsr >> 1;
                        if (bit_out) begin
                            m_lfsr = m_lfsr ^ LFSR_TAPS;
                        end
                        m_nlvl[ch] = bit_out ? 5'h1F : 5'h00;
                    end
                    m_nacc[ch] = acc[10:0];
                    smp = m_nlvl[ch];
                end else if (m_ctl[ch][6]) begin
                    smp = m_direct[ch];
                end else begin
                    d = (m_period[ch] == 0) ? 32'd4096 : 32'(m_period[ch]);
                    pos = m_phase[ch][16:12];
                    inc = (32'(m_ratio) * 32'd16) / d;
                    m_phase[ch] = m_phase[ch] + inc[16:0];
                    smp = m_wave[ch][pos];
                end
                left += vl * (smp - 16);
                right += vr * (smp - 16);
            end
        end
        s.left = left[15:0];
        s.right = right[15:0];
        sample_queue.push_back(s);
    endtask

    // Offer one item and wait for its transfer; the copy advances on acceptance.
    // Valid stays up after the transfer so that back-to-back items need no gap.
    task automatic send_item(input logic act, input logic [3:0] addr, input logic [7:0] v);
        int gap;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_address <= addr;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_mix(act, addr, v);
        if (act == OP_TICK) ticks_sent++; else writes_sent++;
    endtask

    // Stop offering, wait for every expected sample, then let trailing writes settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sample_queue.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_ratio(input logic [RATIO_W-1:0] r);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= r;
        @(posedge aclk);
        cfg_we <= 1'b0;
        m_ratio = r;
        configs_done++;
        @(posedge aclk);
    endtask

    // Receiver: random bursts of stall, an optional long hold-off, and checking.
    initial begin
        int burst;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                rx_hold_req = 1'b0;
            end
            if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 17);
                m_ready <= 1'b0;
                repeat (burst) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            samples_seen++;
            if (sample_queue.size() == 0) begin
                $display("%0t: unexpected sample L=%0d R=%0d", $time,
                         m_left_sample, m_right_sample);
                errors++;
            end else begin
                if (m_left_sample !== sample_queue[0].left) begin
                    $display("%0t: left expected %0d actual %0d", $time,
                             $signed(sample_queue[0].left), m_left_sample);
                    errors++;
                end
                if (m_right_sample !== sample_queue[0].right) begin
                    $display("%0t: right expected %0d actual %0d", $time,
                             $signed(sample_queue[0].right), m_right_sample);
                    errors++;
                end
                void'(sample_queue.pop_front());
            end
        end
    end

    // Watchdog on the cycle count.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d samples pending", $time, sample_queue.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Directed rows: action, address, value, and whether a typed-in sample applies.
    typedef struct {
        logic act;
        logic [3:0] addr;
        logic [7:0] v;
        bit typed;
        logic [15:0] left;
        logic [15:0] right;
    } row_t;

    // Random register write biased toward useful setups of a voice.
    task automatic random_write();
        logic [3:0] addr;
        logic [7:0] v;
        int pick;
        pick = $urandom_range(0, 99);
        v = 8'($urandom);
        if (pick < 10) addr = ADDR_SELECT;
        else if (pick < 14) addr = ADDR_GBAL;
        else if (pick < 22) addr = ADDR_PERIOD_LO;
        else if (pick < 28) addr = ADDR_PERIOD_HI;
        else if (pick < 40) begin
            addr = ADDR_CONTROL;
            // Mostly enabled voices.
            if ($urandom_range(0, 3) != 0) v[7] = 1'b1;
        end
        else if (pick < 46) addr = ADDR_CHBAL;
        else if (pick < 84) addr = ADDR_DATA;
        else if (pick < 94) addr = ADDR_NOISE;
        else addr = 4'(8 + $urandom_range(0, 7));
        send_item(OP_WRITE, addr, v);
    endtask

    initial begin
        row_t rows[$];
        row_t r;
        stereo_t exp_s;
        logic [RATIO_W-1:0] ratios[6];
        reset_generator_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // After reset every voice is off, so the first ticks are silent.
        rows.push_back('{OP_TICK, 4'd0, 8'h00, 1'b1, 16'd0, 16'd0});
        rows.push_back('{OP_TICK, 4'd15, 8'hFF, 1'b1, 16'd0, 16'd0});
        // Voice 0 direct at level 31, full balances: 341 * (31 - 16) on both sides.
        rows.push_back('{OP_WRITE, ADDR_SELECT, 8'h00, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_WRITE, ADDR_GBAL, 8'hFF, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_WRITE, ADDR_CHBAL, 8'hFF, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_WRITE, ADDR_CONTROL, 8'hDF, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_WRITE, ADDR_DATA, 8'hFF, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_TICK, 4'd0, 8'h00, 1'b1, 16'd5115, 16'd5115});
        // Direct level 0 gives 341 * -16.
        rows.push_back('{OP_WRITE, ADDR_DATA, 8'h00, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_TICK, 4'd0, 8'h00, 1'b1, 16'hEAB0, 16'hEAB0});
        // Hold mode ignores data, then the direct bit falls and the wave plays.
        rows.push_back('{OP_WRITE, ADDR_CONTROL, 8'h5F, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_WRITE, ADDR_DATA, 8'h1F, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_WRITE, ADDR_CONTROL, 8'h9F, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_WRITE, ADDR_DATA, 8'h1F, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_WRITE, ADDR_PERIOD_LO, 8'hFF, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_WRITE, ADDR_PERIOD_HI, 8'hFF, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_TICK, 4'd0, 8'h00, 1'b0, 16'd0, 16'd0});
        // Noise on voice 5, fastest rate; then register set 7 and a high address.
        rows.push_back('{OP_WRITE, ADDR_SELECT, 8'hFD, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_WRITE, ADDR_CONTROL, 8'h9F, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_WRITE, ADDR_CHBAL, 8'hF0, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_WRITE, ADDR_NOISE, 8'h9F, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_TICK, 4'd0, 8'h00, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_WRITE, ADDR_SELECT, 8'h07, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_WRITE, ADDR_CONTROL, 8'hFF, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_WRITE, 4'd9, 8'hAA, 1'b0, 16'd0, 16'd0});
        rows.push_back('{OP_TICK, 4'd0, 8'h00, 1'b0, 16'd0, 16'd0});

        foreach (rows[i]) begin
            r = rows[i];
            send_item(r.act, r.addr, r.v);
            // A typed-in row overrides the last prediction with its own figure.
            if (r.typed) begin
                exp_s.left = r.left;
                exp_s.right = r.right;
                if ((sample_queue[$].left !== exp_s.left) ||
                    (sample_queue[$].right !== exp_s.right)) begin
                    $display("%0t: row %0d predicted L=%0d R=%0d, table %0d %0d", $time, i,
                             $signed(sample_queue[$].left), $signed(sample_queue[$].right),
                             $signed(r.left), $signed(r.right));
                    errors++;
                end
                sample_queue[$] = exp_s;
            end
        end

        // Random phases, each under its own ratio, extremes among them.
        ratios = '{24'd1, 24'hFFFFFF, 24'd0, 24'd20779, 24'd5000, 24'h123456};
        for (int p = 0; p < 6; p++) begin
            write_ratio(p == 2 ? 24'($urandom) : ratios[p]);
            if (p == 2) write_ratio(ratios[2]);
            if (p == 5) begin
                // Quiet tail: no idling on either side.
                rx_idle_on = 1'b0;
                tx_idle_on = 1'b0;
            end
            if (p == 1) begin
                // Long receiver hold-off while items keep coming.
                rx_hold_req = 1'b1;
            end
            for (int n = 0; n < 190; n++) begin
                if ($urandom_range(0, 99) < 35) send_item(OP_TICK, 4'($urandom), 8'($urandom));
                else random_write();
            end
            if (p == 3) begin
                // Sender pause until every sample has arrived.
                drain_results();
            end
        end

        drain_results();
        $display("Covered %0d writes and %0d ticks, %0d samples checked, %0d ratios.",
                 writes_sent, ticks_sent, samples_seen, configs_done);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
+incdir+hw/rtl
hw/rtl/wpm_pkg.sv
hw/rtl/wpm_front.sv
hw/rtl/wpm_div.sv
hw/rtl/wpm_core.sv
hw/rtl/wavetable_psg_mixer_top.sv
bench/tb_wavetable_psg_mixer_top.sv
